// File: sv/volume_gradient_vector_3d_assert.svh
// Assertion macros shared by the gradient block modules
`ifndef VOLUME_GRADIENT_VECTOR_3D_ASSERT_SVH
`define VOLUME_GRADIENT_VECTOR_3D_ASSERT_SVH

// Implication checked every clock, quiet during reset
`define VGV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet during reset
`define VGV_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/vgv_pkg.sv
`default_nettype none
package vgv_pkg;
    localparam int MAX_DIM_X_DEF      = 256;
    localparam int MAX_DIM_Y_DEF      = 256;
    localparam int MAX_DIM_Z_DEF      = 4096;
    localparam int COEF_FRAC_BITS_DEF = 12;
    localparam int OUT_FRAC_BITS      = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIM_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_Z = 3'd5;

    localparam logic OP_VOXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;
endpackage
`default_nettype wire

// File: sv/volume_gradient_vector_3d.sv
`default_nettype none
// Channel  | Dir | Payload
// s_axis   | in  | tdata[15:0]=voxel; tuser=op
// m_axis   | out | tdata grad_x[31:0], grad_y[63:32], grad_z[95:64]; tlast=last_voxel
// cfg      | in  | i_cfg_we, i_cfg_idx, i_cfg_data (48 bits)
// One transaction per cycle while the output queue has room; a result passes
// through store read, difference, multiply, add and shift into the queue.
// The result of voxel v comes with input transaction v + dim_x*dim_y.
// Input stalls only when the eight-entry output queue could fill.
// Synchronous active-low reset clears counters and queue; no clearing pass.
module volume_gradient_vector_3d #(
    parameter int MAX_DIM_X      = vgv_pkg::MAX_DIM_X_DEF,
    parameter int MAX_DIM_Y      = vgv_pkg::MAX_DIM_Y_DEF,
    parameter int MAX_DIM_Z      = vgv_pkg::MAX_DIM_Z_DEF,
    parameter int COEF_FRAC_BITS = vgv_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [15:0]                     s_axis_tdata,  // voxel
    input  wire logic                            s_axis_tuser,  // op
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [95:0]                          m_axis_tdata,  // grad_x, grad_y, grad_z
    output logic                                 m_axis_tlast,
    input  wire logic                            i_cfg_we,
    input  wire logic [vgv_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [vgv_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import vgv_pkg::*;

    localparam int XW = $clog2(MAX_DIM_X);
    localparam int YW = $clog2(MAX_DIM_Y);
    localparam int ZW = $clog2(MAX_DIM_Z);

    logic [8:0]  r_dim_x, r_dim_y;
    logic [12:0] r_dim_z;
    logic [47:0] r_coef_x, r_coef_y, r_coef_z;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_x <= 9'd256; r_dim_y <= 9'd256; r_dim_z <= 13'd256;
            r_coef_x <= 48'd2048;
            r_coef_y <= 48'd2048 << 16;
            r_coef_z <= 48'd2048 << 32;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DIM_X:  r_dim_x  <= i_cfg_data[8:0];
                REG_DIM_Y:  r_dim_y  <= i_cfg_data[8:0];
                REG_DIM_Z:  r_dim_z  <= i_cfg_data[12:0];
                REG_COEF_X: r_coef_x <= i_cfg_data;
                REG_COEF_Y: r_coef_y <= i_cfg_data;
                REG_COEF_Z: r_coef_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamp dimensions to 1..max
    logic [XW:0] dx;
    logic [YW:0] dy;
    logic [ZW:0] dz;
    always_comb begin
        if (r_dim_x == '0) dx = (XW+1)'(1);
        else if (32'(r_dim_x) > MAX_DIM_X) dx = (XW+1)'(MAX_DIM_X);
        else dx = (XW+1)'(r_dim_x);
        if (r_dim_y == '0) dy = (YW+1)'(1);
        else if (32'(r_dim_y) > MAX_DIM_Y) dy = (YW+1)'(MAX_DIM_Y);
        else dy = (YW+1)'(r_dim_y);
        if (r_dim_z == '0) dz = (ZW+1)'(1);
        else if (32'(r_dim_z) > MAX_DIM_Z) dz = (ZW+1)'(MAX_DIM_Z);
        else dz = (ZW+1)'(r_dim_z);
    end

    logic          space, fire;
    logic          we, emit, last;
    logic [1:0]    wslot, sc, sp, sn;
    logic [YW-1:0] wy, y, yp, yn;
    logic [XW-1:0] wx, x, xp, xn;
    logic [15:0]   wdata;

    assign s_axis_tready = space;
    assign fire = s_axis_tvalid && s_axis_tready;

    vgv_front #(.MAX_DIM_X(MAX_DIM_X), .MAX_DIM_Y(MAX_DIM_Y), .MAX_DIM_Z(MAX_DIM_Z))
    u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_fire(fire),
        .i_op(s_axis_tuser), .i_voxel(s_axis_tdata),
        .i_dx(dx), .i_dy(dy), .i_dz(dz),
        .o_we(we), .o_wslot(wslot), .o_wy(wy), .o_wx(wx), .o_wdata(wdata),
        .o_emit(emit), .o_sc(sc), .o_sp(sp), .o_sn(sn),
        .o_y(y), .o_yp(yp), .o_yn(yn), .o_x(x), .o_xp(xp), .o_xn(xn),
        .o_last(last)
    );

    vgv_back #(.MAX_DIM_X(MAX_DIM_X), .MAX_DIM_Y(MAX_DIM_Y),
               .COEF_FRAC_BITS(COEF_FRAC_BITS))
    u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_we(we), .i_wslot(wslot), .i_wy(wy), .i_wx(wx), .i_wdata(wdata),
        .i_emit(emit), .i_sc(sc), .i_sp(sp), .i_sn(sn),
        .i_y(y), .i_yp(yp), .i_yn(yn), .i_x(x), .i_xp(xp), .i_xn(xn),
        .i_last(last),
        .i_coef_x(r_coef_x), .i_coef_y(r_coef_y), .i_coef_z(r_coef_z),
        .o_space(space),
        .o_tvalid(m_axis_tvalid), .i_tready(m_axis_tready),
        .o_tdata(m_axis_tdata), .o_tlast(m_axis_tlast)
    );
endmodule
`default_nettype wire

// File: sv/vgv_ram.sv
`default_nettype none
module vgv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: sv/vgv_front.sv
`default_nettype none
`include "volume_gradient_vector_3d_assert.svh"
// Front: accepts transactions, tracks input and output positions, issues
// one write per stored sample and six neighbour read addresses per output voxel.
module vgv_front #(
    parameter int MAX_DIM_X = 256,
    parameter int MAX_DIM_Y = 256,
    parameter int MAX_DIM_Z = 4096,
    localparam int XW = $clog2(MAX_DIM_X),
    localparam int YW = $clog2(MAX_DIM_Y),
    localparam int ZW = $clog2(MAX_DIM_Z)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_fire,     // input transaction accepted
    input  wire logic          i_op,
    input  wire logic [15:0]   i_voxel,
    input  wire logic [XW:0]   i_dx,       // clamped dimensions
    input  wire logic [YW:0]   i_dy,
    input  wire logic [ZW:0]   i_dz,
    // store write
    output logic               o_we,
    output logic [1:0]         o_wslot,
    output logic [YW-1:0]      o_wy,
    output logic [XW-1:0]      o_wx,
    output logic [15:0]        o_wdata,
    // issued output voxel
    output logic               o_emit,
    output logic [1:0]         o_sc,
    output logic [1:0]         o_sp,
    output logic [1:0]         o_sn,
    output logic [YW-1:0]      o_y,
    output logic [YW-1:0]      o_yp,
    output logic [YW-1:0]      o_yn,
    output logic [XW-1:0]      o_x,
    output logic [XW-1:0]      o_xp,
    output logic [XW-1:0]      o_xn,
    output logic               o_last
);
    import vgv_pkg::*;

    // input position as x/y/z counters plus a slot counter and a fill flag
    logic [XW-1:0] r_ix;
    logic [YW-1:0] r_iy;
    logic [ZW:0]   r_iz;
    logic [1:0]    r_islot;
    logic          r_primed;   // first plane fully received
    // output position
    logic [XW-1:0] r_ox;
    logic [YW-1:0] r_oy;
    logic [ZW-1:0] r_oz;
    logic [1:0]    r_osc;
    logic [1:0]    r_osp;

    logic          in_vol;
    logic          x_end, y_end;
    logic          ox_end, oy_end, oz_end;
    logic [1:0]    slot_nx;

    assign in_vol = ({1'b0, r_iz} < {1'b0, i_dz});
    assign x_end  = ({1'b0, r_ix} >= i_dx - 1'b1);
    assign y_end  = ({1'b0, r_iy} >= i_dy - 1'b1);
    assign ox_end = ({1'b0, r_ox} >= i_dx - 1'b1);
    assign oy_end = ({1'b0, r_oy} >= i_dy - 1'b1);
    assign oz_end = ({1'b0, r_oz} >= i_dz - 1'b1);
    assign slot_nx = (r_osc == 2'd2) ? 2'd0 : r_osc + 2'd1;

    // write of the arriving sample
    assign o_we    = i_fire && in_vol;
    assign o_wslot = r_islot;
    assign o_wy    = r_iy;
    assign o_wx    = r_ix;
    assign o_wdata = (i_op == OP_DRAIN) ? 16'd0 : i_voxel;

    // neighbour addresses of the output voxel, clamped at faces
    assign o_emit = i_fire && r_primed;
    assign o_sc   = r_osc;
    assign o_sp   = (r_oz == '0) ? r_osc : r_osp;
    assign o_sn   = oz_end ? r_osc : slot_nx;
    assign o_y    = r_oy;
    assign o_yp   = (r_oy == '0) ? r_oy : r_oy - 1'b1;
    assign o_yn   = oy_end ? r_oy : r_oy + 1'b1;
    assign o_x    = r_ox;
    assign o_xp   = (r_ox == '0) ? r_ox : r_ox - 1'b1;
    assign o_xn   = ox_end ? r_ox : r_ox + 1'b1;
    assign o_last = ox_end && oy_end && oz_end;

    // position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ix <= '0; r_iy <= '0; r_iz <= '0; r_islot <= '0; r_primed <= 1'b0;
            r_ox <= '0; r_oy <= '0; r_oz <= '0; r_osc <= '0; r_osp <= 2'd2;
        end else if (i_fire) begin
            if (o_emit && o_last) begin
                r_ix <= '0; r_iy <= '0; r_iz <= '0; r_islot <= '0;
                r_primed <= 1'b0;
                r_ox <= '0; r_oy <= '0; r_oz <= '0; r_osc <= '0; r_osp <= 2'd2;
            end else begin
                if (in_vol) begin
                    if (!x_end) begin
                        r_ix <= r_ix + 1'b1;
                    end else begin
                        r_ix <= '0;
                        if (!y_end) begin
                            r_iy <= r_iy + 1'b1;
                        end else begin
                            r_iy <= '0;
                            r_iz <= r_iz + 1'b1;
                            r_islot <= (r_islot == 2'd2) ? 2'd0 : r_islot + 2'd1;
                            r_primed <= 1'b1;
                        end
                    end
                end
                if (o_emit) begin
                    if (!ox_end) begin
                        r_ox <= r_ox + 1'b1;
                    end else begin
                        r_ox <= '0;
                        if (!oy_end) begin
                            r_oy <= r_oy + 1'b1;
                        end else begin
                            r_oy  <= '0;
                            r_oz  <= r_oz + 1'b1;
                            r_osp <= r_osc;
                            r_osc <= slot_nx;
                        end
                    end
                end
            end
        end
    end

    `VGV_ASSERT_IMP(a_slot_range, i_clk, i_rst_n, 1'b1,
        r_islot != 2'd3 && r_osc != 2'd3, "slot counter out of range")
    `VGV_ASSERT_IMP(a_emit_primed, i_clk, i_rst_n, o_emit, r_primed,
        "result issued before a plane was stored")
    `VGV_ASSERT_NXT(a_last_clears, i_clk, i_rst_n, o_emit && o_last,
        !r_primed && r_ox == '0 && r_oz == '0, "counters not cleared after last")
endmodule
`default_nettype wire

// File: sv/vgv_back.sv
`default_nettype none
`include "volume_gradient_vector_3d_assert.svh"
// Back: three-plane store, differences, 3x3 mix, output skid queue.
module vgv_back #(
    parameter int MAX_DIM_X      = 256,
    parameter int MAX_DIM_Y      = 256,
    parameter int COEF_FRAC_BITS = 12,
    localparam int XW = $clog2(MAX_DIM_X),
    localparam int YW = $clog2(MAX_DIM_Y),
    localparam int PW = XW + YW,
    localparam int SH = COEF_FRAC_BITS - 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_we,
    input  wire logic [1:0]    i_wslot,
    input  wire logic [YW-1:0] i_wy,
    input  wire logic [XW-1:0] i_wx,
    input  wire logic [15:0]   i_wdata,
    input  wire logic          i_emit,
    input  wire logic [1:0]    i_sc,
    input  wire logic [1:0]    i_sp,
    input  wire logic [1:0]    i_sn,
    input  wire logic [YW-1:0] i_y,
    input  wire logic [YW-1:0] i_yp,
    input  wire logic [YW-1:0] i_yn,
    input  wire logic [XW-1:0] i_x,
    input  wire logic [XW-1:0] i_xp,
    input  wire logic [XW-1:0] i_xn,
    input  wire logic          i_last,
    input  wire logic [47:0]   i_coef_x,
    input  wire logic [47:0]   i_coef_y,
    input  wire logic [47:0]   i_coef_z,
    output logic               o_space,   // room for one more issue
    output logic               o_tvalid,
    input  wire logic          i_tready,
    output logic [95:0]        o_tdata,
    output logic               o_tlast
);
    import vgv_pkg::*;

    localparam int DEPTH = 1 << (PW + 2);
    localparam int AW    = PW + 2;
    localparam int NRD   = 6;
    localparam int QD    = 8;

    // read addresses: x-next, x-prev, y-next, y-prev, z-next, z-prev
    logic [AW-1:0] raddr [NRD];
    logic [15:0]   rdata [NRD];
    logic [AW-1:0] waddr;
    assign raddr[0] = {i_sc, i_y,  i_xn};
    assign raddr[1] = {i_sc, i_y,  i_xp};
    assign raddr[2] = {i_sc, i_yn, i_x};
    assign raddr[3] = {i_sc, i_yp, i_x};
    assign raddr[4] = {i_sn, i_y,  i_x};
    assign raddr[5] = {i_sp, i_y,  i_x};
    assign waddr    = {i_wslot, i_wy, i_wx};

    // one copy of the store per neighbour read port
    for (genvar g = 0; g < NRD; g++) begin : g_bank
        vgv_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ram (
            .i_clk   (i_clk),
            .i_we    (i_we),
            .i_waddr (waddr),
            .i_wdata (i_wdata),
            .i_raddr (raddr[g]),
            .o_rdata (rdata[g])
        );
    end

    // sample written in the read cycle (z-next of the output voxel) wins
    logic [NRD-1:0] r_byp;
    logic [15:0]    r_wbyp;
    logic [15:0]    rdq [NRD];

    always_ff @(posedge i_clk) begin
        r_wbyp <= i_wdata;
        for (int b = 0; b < NRD; b++) begin
            r_byp[b] <= i_we && (raddr[b] == waddr);
        end
    end

    always_comb begin
        for (int b = 0; b < NRD; b++) begin
            rdq[b] = r_byp[b] ? r_wbyp : rdata[b];
        end
    end

    // pipeline: s1 read, s2 diff, s3 products, s4 sum, s5 shift into queue
    logic        r_v1, r_v2, r_v3, r_v4;
    logic        r_l1, r_l2, r_l3, r_l4;
    logic signed [16:0] r_d [3];
    logic signed [33:0] r_p [9];
    logic signed [35:0] r_s [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_emit; r_v2 <= r_v1; r_v3 <= r_v2; r_v4 <= r_v3;
        end
    end

    logic signed [15:0] cf [9];
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            cf[r]     = $signed(i_coef_x[16*r +: 16]);
            cf[3 + r] = $signed(i_coef_y[16*r +: 16]);
            cf[6 + r] = $signed(i_coef_z[16*r +: 16]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_l1 <= i_last; r_l2 <= r_l1; r_l3 <= r_l2; r_l4 <= r_l3;
        for (int a = 0; a < 3; a++) begin
            r_d[a] <= $signed({rdq[2*a][15], rdq[2*a]})
                    - $signed({rdq[2*a+1][15], rdq[2*a+1]});
        end
        for (int k = 0; k < 9; k++) begin
            r_p[k] <= r_d[k % 3] * cf[k];
        end
        for (int o = 0; o < 3; o++) begin
            r_s[o] <= 36'(r_p[3*o]) + 36'(r_p[3*o+1]) + 36'(r_p[3*o+2]);
        end
    end

    // output queue; sized for every transaction in flight plus margin
    logic [96:0]        r_q [QD];
    logic [2:0]         r_wp, r_rp;
    logic [3:0]         r_cnt;
    logic               pop;
    logic signed [35:0] sh [3];
    logic [4:0]         infl;

    always_comb begin
        for (int o = 0; o < 3; o++) begin
            sh[o] = r_s[o] >>> SH;
        end
    end

    assign pop      = o_tvalid && i_tready;
    assign o_tvalid = (r_cnt != '0);
    assign o_tdata  = r_q[r_rp][95:0];
    assign o_tlast  = r_q[r_rp][96];
    assign infl     = 5'(r_cnt) + 5'(r_v1) + 5'(r_v2) + 5'(r_v3) + 5'(r_v4);
    assign o_space  = infl < 5'(QD);

    always_ff @(posedge i_clk) begin
        if (r_v4) begin
            r_q[r_wp] <= {r_l4, sh[2][31:0], sh[1][31:0], sh[0][31:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (r_v4) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + 4'(r_v4) - 4'(pop);
        end
    end

    `VGV_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, 1'b1, r_cnt <= 4'(QD),
        "output queue overflow")
    `VGV_ASSERT_IMP(a_issue_room, i_clk, i_rst_n, i_emit, o_space,
        "issue without queue room")
    `VGV_ASSERT_NXT(a_hold_result, i_clk, i_rst_n, o_tvalid && !i_tready,
        o_tvalid && $stable({o_tlast, o_tdata}), "result changed while waiting")
endmodule
`default_nettype wire

// File: tb/volume_gradient_vector_3d_test.sv
`timescale 1ns / 1ps

module volume_gradient_vector_3d_test;
    import vgv_pkg::*;

    localparam int PLANE_SLOTS = MAX_DIM_X_DEF * MAX_DIM_Y_DEF;
    localparam int GRAD_SHIFT  = COEF_FRAC_BITS_DEF - OUT_FRAC_BITS;
    // indexes past the register list; writes there are dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
    localparam int IDLE_LIMIT  = 3000;
    localparam int LONG_HOLD   = 400;

    typedef struct packed {
        logic signed [31:0] gx;
        logic signed [31:0] gy;
        logic signed [31:0] gz;
        logic               last;
    } grad_t;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [47:0]          data;
        logic                 op;
        logic [15:0]          vox;
        bit                   typed;
        grad_t                want;
    } stim_row_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic [15:0]           s_data = '0;
    logic                  s_user = 1'b0;
    logic                  s_axis_tready;
    logic                  m_axis_tvalid;
    logic                  m_ready = 1'b0;
    logic [95:0]           m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    volume_gradient_vector_3d dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),      // voxel
        .s_axis_tuser  (s_user),      // op
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata), // grad_x, grad_y, grad_z
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // shadow of the block: plane store, counters, registers
    logic [15:0]     plane_mem [0:3*PLANE_SLOTS-1];
    longint unsigned in_pos = 0;
    int unsigned     col_ptr = 0, row_ptr = 0, plane_ptr = 0;
    logic [8:0]      reg_dx = 9'd256, reg_dy = 9'd256;
    logic [12:0]     reg_dz = 13'd256;
    logic [47:0]     coef_x = 48'd2048;
    logic [47:0]     coef_y = 48'd2048 << 16;
    logic [47:0]     coef_z = 48'd2048 << 32;

    grad_t pending_grads[$];
    bit    failed = 1'b0;
    bit    hold_req = 1'b0;
    int    tx_gap_max = 12;
    int    rx_gap_max = 12;
    int    idle_cycles = 0;

    function automatic int unsigned sat_dim(int unsigned d, int unsigned hi);
        if (d < 1) return 1;
        return (d > hi) ? hi : d;
    endfunction

    function automatic int sample_at(int unsigned slot, int unsigned y, int unsigned x);
        return int'($signed(plane_mem[slot*PLANE_SLOTS + y*MAX_DIM_X_DEF + x]));
    endfunction

    function automatic logic [31:0] mix_row(logic [47:0] w, int ddx, int ddy, int ddz);
        longint acc;
        acc = longint'(ddx) * longint'($signed(w[15:0]))
            + longint'(ddy) * longint'($signed(w[31:16]))
            + longint'(ddz) * longint'($signed(w[47:32]));
        acc = acc >>> GRAD_SHIFT;
        return acc[31:0];
    endfunction

    function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [47:0] val);
        case (idx)
            REG_DIM_X:  reg_dx = val[8:0];
            REG_DIM_Y:  reg_dy = val[8:0];
            REG_DIM_Z:  reg_dz = val[12:0];
            REG_COEF_X: coef_x = val;
            REG_COEF_Y: coef_y = val;
            REG_COEF_Z: coef_z = val;
            default: ;
        endcase
    endfunction

    // one input transaction through the shadow; emits at most one gradient
    function automatic void predict_grad(input logic op, input logic [15:0] vox,
                                         output bit emits, output grad_t g);
        int unsigned     nx, ny, nz, x, y, z, xp, xn, yp, yn, sp, sc, sn;
        longint unsigned plane_sz, total;
        int              ddx, ddy, ddz;
        nx = sat_dim(reg_dx, MAX_DIM_X_DEF);
        ny = sat_dim(reg_dy, MAX_DIM_Y_DEF);
        nz = sat_dim(reg_dz, MAX_DIM_Z_DEF);
        plane_sz = longint'(nx) * ny;
        total = plane_sz * nz;
        emits = 1'b0;
        g = '0;
        if (in_pos < total)
            plane_mem[((in_pos / plane_sz) % 3) * PLANE_SLOTS
                      + ((in_pos / nx) % ny) * MAX_DIM_X_DEF + (in_pos % nx)]
                = (op == OP_DRAIN) ? 16'h0 : vox;
        if (in_pos < plane_sz) begin
            in_pos++;
            return;
        end
        x = col_ptr; y = row_ptr; z = plane_ptr;
        xp = (x == 0) ? 0 : x - 1;
        xn = (x >= nx - 1) ? x : x + 1;
        yp = (y == 0) ? 0 : y - 1;
        yn = (y >= ny - 1) ? y : y + 1;
        sc = z % 3;
        sp = (z == 0) ? sc : (z - 1) % 3;
        sn = (z >= nz - 1) ? sc : (z + 1) % 3;
        ddx = sample_at(sc, y, xn) - sample_at(sc, y, xp);
        ddy = sample_at(sc, yn, x) - sample_at(sc, yp, x);
        ddz = sample_at(sn, y, x) - sample_at(sp, y, x);
        g.gx = mix_row(coef_x, ddx, ddy, ddz);
        g.gy = mix_row(coef_y, ddx, ddy, ddz);
        g.gz = mix_row(coef_z, ddx, ddy, ddz);
        g.last = (x >= nx - 1) && (y >= ny - 1) && (z >= nz - 1);
        emits = 1'b1;
        if (g.last) begin
            in_pos = 0; col_ptr = 0; row_ptr = 0; plane_ptr = 0;
        end else begin
            in_pos++;
            if (x < nx - 1) begin
                col_ptr = x + 1;
            end else begin
                col_ptr = 0;
                if (y < ny - 1) begin
                    row_ptr = y + 1;
                end else begin
                    row_ptr = 0;
                    plane_ptr = z + 1;
                end
            end
        end
    endfunction

    // wait for every gradient, let the pipe settle, then write a register
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [47:0] val);
        wait (pending_grads.size() == 0);
        repeat (10) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        apply_cfg(idx, val);
        cfg_we   <= 1'b0;
    endtask

    // offer one transaction; on acceptance step the shadow
    task automatic send_item(logic op, logic [15:0] vox, bit typed, grad_t want);
        int    gap;
        bit    emits;
        grad_t g;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= vox;
        s_user  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_grad(op, vox, emits, g);
        if (emits)
            pending_grads.push_back(typed ? want : g);
    endtask

    function automatic logic [15:0] rand_voxel();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_weight();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // result side: random stalls, one long hold on request
    initial begin : result_side
        int    gap;
        grad_t want;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 1'b0;
            end
            gap = $urandom_range(0, rx_gap_max);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            if (pending_grads.size() == 0) begin
                $error("unexpected gradient transaction");
                failed = 1'b1;
            end else begin
                want = pending_grads.pop_front();
                if (m_axis_tdata[31:0] !== want.gx) begin
                    $error("grad_x expected %0d got %0d", want.gx,
                           $signed(m_axis_tdata[31:0]));
                    failed = 1'b1;
                end
                if (m_axis_tdata[63:32] !== want.gy) begin
                    $error("grad_y expected %0d got %0d", want.gy,
                           $signed(m_axis_tdata[63:32]));
                    failed = 1'b1;
                end
                if (m_axis_tdata[95:64] !== want.gz) begin
                    $error("grad_z expected %0d got %0d", want.gz,
                           $signed(m_axis_tdata[95:64]));
                    failed = 1'b1;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last_voxel expected %0d got %0d", want.last, m_axis_tlast);
                    failed = 1'b1;
                end
            end
        end
    end

    // watchdog: too long without any transaction or register write
    always @(posedge i_clk) begin
        if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("volume_gradient_vector_3d: mismatch");
            $finish;
        end
    end

    initial begin : stimulus
        stim_row_t       rows[$];
        stim_row_t       r;
        grad_t           none;
        grad_t           g_edge;
        int              sent;
        int              phase;
        int              sel;
        int unsigned     nx, ny, nz, vol_len, plane_len;
        logic [8:0]      wdx, wdy;
        logic [12:0]     wdz;

        for (int i = 0; i < 3*PLANE_SLOTS; i++) plane_mem[i] = 16'h0;
        none = '0;
        g_edge = '{gx: 32'sd8388480, gy: 0, gz: 0, last: 1'b0};

        // directed table
        r = '{default: '0};
        r.is_cfg = 1; r.idx = REG_DIM_X; r.data = 48'd1; rows.push_back(r);
        r.idx = REG_DIM_Y; rows.push_back(r);
        r.idx = REG_DIM_Z; rows.push_back(r);
        // single voxel: all neighbors clamp to itself
        r = '{default: '0};
        r.op = OP_VOXEL; r.vox = 16'h7FFF; rows.push_back(r);
        r.op = OP_DRAIN; r.typed = 1; r.want = '{0, 0, 0, 1'b1}; rows.push_back(r);
        r.op = OP_VOXEL; r.vox = 16'h8000; r.typed = 0; rows.push_back(r);
        // voxel transaction past the volume: sample ignored
        r.vox = 16'd5; r.typed = 1; r.want = '{0, 0, 0, 1'b1}; rows.push_back(r);
        // two-voxel row, full-scale x difference through the reset weights
        r = '{default: '0};
        r.is_cfg = 1; r.idx = REG_DIM_X; r.data = 48'd2; rows.push_back(r);
        r = '{default: '0};
        r.op = OP_VOXEL; r.vox = 16'h8000; rows.push_back(r);
        r.vox = 16'h7FFF; rows.push_back(r);
        r.op = OP_DRAIN; r.typed = 1; r.want = g_edge; rows.push_back(r);
        g_edge.last = 1'b1;
        r.want = g_edge; rows.push_back(r);
        // zero dimension saturates; drain inside the volume stores zero
        r = '{default: '0};
        r.is_cfg = 1; r.idx = REG_DIM_X; r.data = 48'd0; rows.push_back(r);
        r.idx = REG_DIM_Y; r.data = 48'd2; rows.push_back(r);
        r.idx = REG_DIM_Z; rows.push_back(r);
        r.idx = REG_COEF_X; r.data = 48'h8000_7FFF_7FFF; rows.push_back(r);
        r.idx = REG_COEF_Y; r.data = 48'h7FFF_8000_0001; rows.push_back(r);
        r.idx = REG_COEF_Z; r.data = 48'h8000_8000_8000; rows.push_back(r);
        r.idx = REG_SPARE_A; r.data = 48'hFFFF_FFFF_FFFF; rows.push_back(r);
        r = '{default: '0};
        r.op = OP_VOXEL; r.vox = 16'h7FFF; rows.push_back(r);
        r.op = OP_DRAIN; r.vox = 16'h1234; rows.push_back(r);
        r.op = OP_VOXEL; r.vox = 16'h8000; rows.push_back(r);
        r.vox = 16'h0001; rows.push_back(r);
        r.op = OP_DRAIN; rows.push_back(r);
        r.op = OP_VOXEL; r.vox = 16'hFFFF; rows.push_back(r);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) begin
            if (rows[i].is_cfg) begin
                if (s_valid) s_valid <= 1'b0;
                write_reg(rows[i].idx, rows[i].data);
            end else begin
                send_item(rows[i].op, rows[i].vox, rows[i].typed, rows[i].want);
            end
        end

        // random volumes; the first is a long one that carries the long hold
        sent = 0;
        phase = 0;
        while (sent < 2000) begin
            tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
            rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
            if (phase == 0 || $urandom_range(0, 2) != 0) begin
                sel = (phase == 0) ? 1 : int'($urandom_range(0, 9));
                case (sel)
                    0: begin
                        wdx = 9'($urandom_range(257, 511)); wdy = 9'd1; wdz = 13'd1;
                    end
                    1: begin wdx = 9'd256; wdy = 9'd1; wdz = 13'd2; end
                    2: begin wdx = 9'd1; wdy = 9'd256; wdz = 13'd2; end
                    3: begin wdx = 9'd0; wdy = 9'd0; wdz = 13'd0; end
                    default: begin
                        wdx = 9'($urandom_range(1, 9));
                        wdy = 9'($urandom_range(1, 6));
                        wdz = 13'($urandom_range(1, 5));
                    end
                endcase
                if (s_valid) s_valid <= 1'b0;
                write_reg(REG_DIM_X, 48'(wdx));
                write_reg(REG_DIM_Y, 48'(wdy));
                write_reg(REG_DIM_Z, 48'(wdz));
                write_reg(REG_COEF_X, {rand_weight(), rand_weight(), rand_weight()});
                write_reg(REG_COEF_Y, {rand_weight(), rand_weight(), rand_weight()});
                write_reg(REG_COEF_Z, {rand_weight(), rand_weight(), rand_weight()});
                if ($urandom_range(0, 3) == 0)
                    write_reg(REG_SPARE_B, {16'($urandom), 32'($urandom)});
            end
            nx = sat_dim(reg_dx, MAX_DIM_X_DEF);
            ny = sat_dim(reg_dy, MAX_DIM_Y_DEF);
            nz = sat_dim(reg_dz, MAX_DIM_Z_DEF);
            plane_len = nx * ny;
            vol_len = plane_len * nz;
            for (int k = 0; k < vol_len; k++) begin
                // results flow by now; the receiver stops while items keep coming
                if (phase == 0 && k == plane_len + 16) hold_req = 1'b1;
                send_item(($urandom_range(0, 15) == 0) ? OP_DRAIN : OP_VOXEL,
                          rand_voxel(), 1'b0, none);
            end
            for (int k = 0; k < plane_len; k++)
                send_item(1'($urandom_range(0, 1)), rand_voxel(), 1'b0, none);
            sent += vol_len + plane_len;
            phase++;
        end
        s_valid <= 1'b0;

        wait (pending_grads.size() == 0);
        repeat (20) @(posedge i_clk);
        if (!failed)
            $display("volume_gradient_vector_3d: match");
        else
            $display("volume_gradient_vector_3d: mismatch");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/vgv_pkg.sv
sv/vgv_ram.sv
sv/vgv_front.sv
sv/vgv_back.sv
sv/volume_gradient_vector_3d.sv
tb/volume_gradient_vector_3d_test.sv
